// File: sv/dms_pkg.sv
// Shared constants, register indexes and control struct of the drift mobility step block.
package dms_pkg;

  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned MEAN_W     = 23;
  localparam int unsigned SPREAD_W   = 22;
  localparam int unsigned LIMITS_W   = 51;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned VEL_W      = 24;
  localparam int unsigned DIM_W      = 16;
  localparam int unsigned AXES       = 3;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned BOUND_LSB  = 48;
  localparam int unsigned ROUND_SHIFT = 16;

  localparam logic [AXIS_W-1:0]   Z_AXIS       = 2'd2;
  localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = 17'h10000;
  localparam logic [LIMITS_W-1:0] LIMITS_RESET = 51'h6_0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA    = 3'd0,
    REG_MEAN_X   = 3'd1,
    REG_MEAN_Y   = 3'd2,
    REG_MEAN_Z   = 3'd3,
    REG_SPREAD_X = 3'd4,
    REG_SPREAD_Y = 3'd5,
    REG_SPREAD_Z = 3'd6,
    REG_LIMITS   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic              busy;
    logic              mul_dev;
    logic              mul_old;
    logic              mul_tgt;
    logic              vel_step;
    logic              pos_step;
    logic              finish;
    logic [AXIS_W-1:0] axis;
  } dms_ctl_t;

endpackage

// File: sv/dms_mul.sv
// Shared signed multiplier with registered product.
module dms_mul #(
  parameter int unsigned AW = 25,
  parameter int unsigned BW = 18
) (
  input  logic                     clk,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  prod
);

  logic signed [AW+BW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

// File: sv/dms_ctrl.sv
// Sequencer stepping the shared multiplier through the three axes of one tick.
module dms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                in_cmd,
  input  logic                out_free,
  output dms_pkg::dms_ctl_t   ctl
);

  typedef enum logic [2:0] {
    S_IDLE, S_DEV, S_OLD, S_TGT, S_VEL, S_POS, S_DONE
  } state_t;

  localparam logic [dms_pkg::AXIS_W-1:0] LAST_AXIS = dms_pkg::AXIS_W'(dms_pkg::AXES - 1);

  state_t                       state_r, state_nxt;
  logic [dms_pkg::AXIS_W-1:0]   axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          axis_nxt  = '0;
          state_nxt = in_cmd ? S_DONE : S_DEV;
        end
      end
      S_DEV: state_nxt = S_OLD;
      S_OLD: state_nxt = S_TGT;
      S_TGT: state_nxt = S_VEL;
      S_VEL: state_nxt = S_POS;
      S_POS: begin
        if (axis_r == LAST_AXIS) begin
          state_nxt = S_DONE;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_DEV;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    ctl          = '0;
    ctl.busy     = (state_r != S_IDLE);
    ctl.mul_dev  = (state_r == S_DEV);
    ctl.mul_old  = (state_r == S_OLD);
    ctl.mul_tgt  = (state_r == S_TGT);
    ctl.vel_step = (state_r == S_VEL);
    ctl.pos_step = (state_r == S_POS);
    ctl.finish   = (state_r == S_DONE) && out_free;
    ctl.axis     = axis_r;
  end

endmodule

// File: sv/drift_mobility_step_top.sv
// Top level of the drift mobility step block: registers, axis datapath and result stage.
//
// Each advance item runs the three axes in turn through one shared multiplier, per axis in
// the steps noise scaling, alpha times old velocity, one-minus-alpha times target,
// rounding with velocity add and wall reflection. A load item skips these steps. The
// sequence is set by the three products per axis queued on the single multiplier.
// in_stall stays high while an item is being worked on; a finished result waits in the
// output register, and the block takes the next item meanwhile. Configuration writes are
// always taken (cfg_ready tied high) and are meant to happen only while no item is in
// flight.
module drift_mobility_step_top #(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned NOISE_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [NOISE_BITS-1:0]              in_noise_x,
  input  logic                               in_sign_x,
  input  logic [NOISE_BITS-1:0]              in_noise_y,
  input  logic                               in_sign_y,
  input  logic [NOISE_BITS-1:0]              in_noise_z,
  input  logic                               in_sign_z,
  input  logic signed [dms_pkg::POS_W-1:0]   in_load_x,
  input  logic signed [dms_pkg::POS_W-1:0]   in_load_y,
  input  logic signed [dms_pkg::POS_W-1:0]   in_load_z,
  // result items
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dms_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [dms_pkg::POS_W-1:0]   out_pos_y,
  output logic signed [dms_pkg::POS_W-1:0]   out_pos_z,
  output logic [dms_pkg::AXES-1:0]           out_bounced,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dms_pkg::LIMITS_W-1:0]       cfg_data
);

  localparam int unsigned VW     = dms_pkg::VEL_W;
  localparam int unsigned PW     = dms_pkg::POS_W;
  localparam int unsigned MA_W   = VW + 1;
  localparam int unsigned MB_W   = (NOISE_BITS + 1 > dms_pkg::ALPHA_W + 1) ?
                                   NOISE_BITS + 1 : dms_pkg::ALPHA_W + 1;
  localparam int unsigned PROD_W = MA_W + MB_W;
  localparam int unsigned ACC_W  = PROD_W + 1;
  localparam int unsigned SUM_W  = PW + 1;
  localparam int unsigned LIM_W  = dms_pkg::DIM_W + FRACTION_BITS;
  localparam int unsigned RW     = ((LIM_W > SUM_W) ? LIM_W : SUM_W) + 2;

  localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(64'sd1 <<< (dms_pkg::ROUND_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] ACC_VMAX  = ACC_W'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ACC_VMIN  = -ACC_VMAX - ACC_W'(1);
  localparam logic signed [VW-1:0]    VEL_MAX   = VW'(ACC_VMAX);
  localparam logic signed [VW-1:0]    VEL_MIN   = VW'(ACC_VMIN);
  localparam logic signed [RW-1:0]    R_PMAX    = RW'((64'sd1 <<< (PW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0]    R_PMIN    = -R_PMAX - RW'(1);

  // configuration registers
  logic [dms_pkg::ALPHA_W-1:0]          alpha_r;
  logic signed [dms_pkg::MEAN_W-1:0]    mean_r   [dms_pkg::AXES];
  logic [dms_pkg::SPREAD_W-1:0]         spread_r [dms_pkg::AXES];
  logic [dms_pkg::LIMITS_W-1:0]         limits_r;

  // model state
  logic signed [PW-1:0]                 pos_r    [dms_pkg::AXES];
  logic signed [VW-1:0]                 vel_r    [dms_pkg::AXES];
  logic [dms_pkg::AXES-1:0]             flip_r;

  // per item working registers
  logic [NOISE_BITS-1:0]                noise_r  [dms_pkg::AXES];
  logic [dms_pkg::AXES-1:0]             sign_r;
  logic signed [VW-1:0]                 target_r, target_nxt;
  logic signed [ACC_W-1:0]              acc_r;
  logic signed [VW-1:0]                 vnew_r, vnew_nxt;
  logic signed [SUM_W-1:0]              psum_r, psum_nxt;
  logic [dms_pkg::AXES-1:0]             bounced_r;

  // result stage
  logic                                 out_valid_r;
  logic signed [PW-1:0]                 out_pos_r [dms_pkg::AXES];
  logic [dms_pkg::AXES-1:0]             out_bounced_r;

  dms_pkg::dms_ctl_t                    ctl;
  logic [dms_pkg::AXIS_W-1:0]           ax;
  logic                                 in_fire, cfg_fire, out_free;

  logic [dms_pkg::ALPHA_W-1:0]          alpha_eff;
  logic signed [MA_W-1:0]               mul_a;
  logic signed [MB_W-1:0]               mul_b;
  logic signed [PROD_W-1:0]             prod;

  logic [dms_pkg::SPREAD_W-1:0]         dev;
  logic signed [VW-1:0]                 mean_ext, mean_eff, dev_s;
  logic signed [ACC_W-1:0]              acc_sum, acc_q;

  logic [dms_pkg::DIM_W-1:0]            dim;
  logic signed [RW-1:0]                 lim, p, p_ref;
  logic                                 bound, hit;
  logic signed [PW-1:0]                 pos_sat;
  logic signed [VW-1:0]                 vel_fin;

  assign in_fire   = in_valid && !in_stall;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = ctl.busy;
  assign cfg_ready = 1'b1;
  assign ax        = ctl.axis;

  dms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_cmd   (in_cmd),
    .out_free (out_free),
    .ctl      (ctl)
  );

  dms_mul #(
    .AW (MA_W),
    .BW (MB_W)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign alpha_eff = (alpha_r > dms_pkg::ALPHA_ONE) ? dms_pkg::ALPHA_ONE : alpha_r;

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ctl.mul_dev) begin
      mul_a = MA_W'(spread_r[ax]);
      mul_b = MB_W'(noise_r[ax]);
    end else if (ctl.mul_old) begin
      mul_a = MA_W'(vel_r[ax]);
      mul_b = MB_W'(alpha_eff);
    end else if (ctl.mul_tgt) begin
      mul_a = MA_W'(target_r);
      mul_b = MB_W'(dms_pkg::ALPHA_ONE - alpha_eff);
    end
  end

  // target step: mean (flipped after a reflection) plus signed deviation
  always_comb begin
    dev        = prod[NOISE_BITS +: dms_pkg::SPREAD_W];
    dev_s      = signed'(VW'(dev));
    mean_ext   = VW'(mean_r[ax]);
    mean_eff   = flip_r[ax] ? -mean_ext : mean_ext;
    target_nxt = mean_eff + (sign_r[ax] ? -dev_s : dev_s);
  end

  // blended velocity, rounded half up and saturated
  always_comb begin
    acc_sum = acc_r + ACC_W'(prod) + ACC_ROUND;
    acc_q   = acc_sum >>> dms_pkg::ROUND_SHIFT;
    if (acc_q > ACC_VMAX) begin
      vnew_nxt = VEL_MAX;
    end else if (acc_q < ACC_VMIN) begin
      vnew_nxt = VEL_MIN;
    end else begin
      vnew_nxt = VW'(acc_q);
    end
    psum_nxt = SUM_W'(pos_r[ax]) + SUM_W'(vnew_nxt);
  end

  // single reflection off the crossed wall
  always_comb begin
    dim   = limits_r[dms_pkg::DIM_W * ax +: dms_pkg::DIM_W];
    bound = limits_r[dms_pkg::BOUND_LSB + ax];
    lim   = signed'(RW'(dim)) <<< FRACTION_BITS;
    p     = RW'(psum_r);
    p_ref = p;
    hit   = 1'b0;
    if (bound) begin
      if (ax != dms_pkg::Z_AXIS) begin
        if (p > lim) begin
          p_ref = (lim <<< 1) - p;
          hit   = 1'b1;
        end else if (p < 0) begin
          p_ref = -p;
          hit   = 1'b1;
        end
      end else begin
        if (p < -lim) begin
          p_ref = -(lim <<< 1) - p;
          hit   = 1'b1;
        end else if (p > 0) begin
          p_ref = -p;
          hit   = 1'b1;
        end
      end
    end
    if (p_ref > R_PMAX) begin
      pos_sat = PW'(R_PMAX);
    end else if (p_ref < R_PMIN) begin
      pos_sat = PW'(R_PMIN);
    end else begin
      pos_sat = PW'(p_ref);
    end
    if (!hit) begin
      vel_fin = vnew_r;
    end else if (vnew_r == VEL_MIN) begin
      vel_fin = VEL_MAX;
    end else begin
      vel_fin = -vnew_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= '0;
      mean_r[0]   <= '0;
      mean_r[1]   <= '0;
      mean_r[2]   <= '0;
      spread_r[0] <= '0;
      spread_r[1] <= '0;
      spread_r[2] <= '0;
      limits_r    <= dms_pkg::LIMITS_RESET;
    end else if (cfg_fire) begin
      unique case (dms_pkg::cfg_reg_t'(cfg_index))
        dms_pkg::REG_ALPHA:    alpha_r     <= cfg_data[dms_pkg::ALPHA_W-1:0];
        dms_pkg::REG_MEAN_X:   mean_r[0]   <= cfg_data[dms_pkg::MEAN_W-1:0];
        dms_pkg::REG_MEAN_Y:   mean_r[1]   <= cfg_data[dms_pkg::MEAN_W-1:0];
        dms_pkg::REG_MEAN_Z:   mean_r[2]   <= cfg_data[dms_pkg::MEAN_W-1:0];
        dms_pkg::REG_SPREAD_X: spread_r[0] <= cfg_data[dms_pkg::SPREAD_W-1:0];
        dms_pkg::REG_SPREAD_Y: spread_r[1] <= cfg_data[dms_pkg::SPREAD_W-1:0];
        dms_pkg::REG_SPREAD_Z: spread_r[2] <= cfg_data[dms_pkg::SPREAD_W-1:0];
        dms_pkg::REG_LIMITS:   limits_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // position, velocity and mean flip state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r[0]  <= '0;
      pos_r[1]  <= '0;
      pos_r[2]  <= '0;
      vel_r[0]  <= '0;
      vel_r[1]  <= '0;
      vel_r[2]  <= '0;
      flip_r    <= '0;
      bounced_r <= '0;
    end else begin
      if (in_fire) begin
        bounced_r <= '0;
        if (in_cmd) begin
          pos_r[0] <= in_load_x;
          pos_r[1] <= in_load_y;
          pos_r[2] <= in_load_z;
        end
      end
      if (ctl.pos_step) begin
        pos_r[ax]     <= pos_sat;
        vel_r[ax]     <= vel_fin;
        flip_r[ax]    <= flip_r[ax] ^ hit;
        bounced_r[ax] <= hit;
      end
    end
  end

  // item capture and working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      noise_r[0] <= in_noise_x;
      noise_r[1] <= in_noise_y;
      noise_r[2] <= in_noise_z;
      sign_r     <= {in_sign_z, in_sign_y, in_sign_x};
    end
    if (ctl.mul_old) target_r <= target_nxt;
    if (ctl.mul_tgt) acc_r    <= ACC_W'(prod);
    if (ctl.vel_step) begin
      vnew_r <= vnew_nxt;
      psum_r <= psum_nxt;
    end
  end

  // result register: hold while stalled, load on finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_pos_r[0]  <= pos_r[0];
      out_pos_r[1]  <= pos_r[1];
      out_pos_r[2]  <= pos_r[2];
      out_bounced_r <= bounced_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_pos_r[0];
  assign out_pos_y   = out_pos_r[1];
  assign out_pos_z   = out_pos_r[2];
  assign out_bounced = out_bounced_r;

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("block not busy after accepting an item");

  // a load item leaves velocities and mean flips untouched
  a_load_keeps_vel: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_cmd |=> $stable(vel_r[0]) && $stable(vel_r[1]) && $stable(vel_r[2])
                          && $stable(flip_r))
    else $error("load item changed velocity state");

  // reflections only on axes whose bound is enabled
  a_bounce_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bounced & ~limits_r[dms_pkg::BOUND_LSB +: dms_pkg::AXES]) == '0)
    else $error("reflection reported on an unbounded axis");

  // a mean flip changes only at the position step of a reflection
  a_flip_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.pos_step |=> $stable(flip_r))
    else $error("mean flip changed outside a position step");

endmodule

// File: test/drift_mobility_step_top_tb.sv
// Self-checking testbench of the drift mobility step block: random ticks, loads and settings.
module drift_mobility_step_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dms_pkg::*;

  localparam int unsigned FRACTION_BITS   = 8;
  localparam int unsigned NOISE_BITS      = 16;
  localparam int          NUM_PHASES      = 8;
  localparam int          ITEMS_PER_PHASE = 120;
  localparam int          HOLDOFF_CYCLES  = 300;
  localparam int          DRAIN_CYCLES    = 40;
  localparam int          CYCLE_LIMIT     = 500000;

  localparam longint VEL_HI = (64'sd1 <<< (VEL_W - 1)) - 1;
  localparam longint VEL_LO = -(64'sd1 <<< (VEL_W - 1));
  localparam longint POS_HI = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint POS_LO = -(64'sd1 <<< (POS_W - 1));

  typedef enum logic {
    CMD_ADVANCE = 1'b0,
    CMD_LOAD    = 1'b1
  } drift_cmd_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_t;

  typedef struct packed {
    drift_cmd_t                      cmd;
    logic [AXES-1:0][NOISE_BITS-1:0] noise;
    logic [AXES-1:0]                 sign;
    logic [AXES-1:0][POS_W-1:0]      load;
  } drift_item_t;

  typedef struct packed {
    logic [AXES-1:0][POS_W-1:0] pos;
    logic [AXES-1:0]            bounced;
  } drift_result_t;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  logic                        in_cmd      = 1'b0;
  logic [NOISE_BITS-1:0]       in_noise_x  = '0;
  logic                        in_sign_x   = 1'b0;
  logic [NOISE_BITS-1:0]       in_noise_y  = '0;
  logic                        in_sign_y   = 1'b0;
  logic [NOISE_BITS-1:0]       in_noise_z  = '0;
  logic                        in_sign_z   = 1'b0;
  logic signed [POS_W-1:0]     in_load_x   = '0;
  logic signed [POS_W-1:0]     in_load_y   = '0;
  logic signed [POS_W-1:0]     in_load_z   = '0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  logic signed [POS_W-1:0]     out_pos_x;
  logic signed [POS_W-1:0]     out_pos_y;
  logic signed [POS_W-1:0]     out_pos_z;
  logic [AXES-1:0]             out_bounced;
  logic                        cfg_valid   = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index   = '0;
  logic [LIMITS_W-1:0]         cfg_data    = '0;

  // shadow copy of the registers and the motion state
  logic [ALPHA_W-1:0]          alpha_cfg   = '0;
  logic signed [MEAN_W-1:0]    mean_cfg [AXES];
  logic [SPREAD_W-1:0]         spread_cfg [AXES];
  logic [LIMITS_W-1:0]         limits_cfg  = LIMITS_RESET;
  logic signed [POS_W-1:0]     pos_track [AXES];
  logic signed [VEL_W-1:0]     vel_track [AXES];
  logic [AXES-1:0]             flip_track  = '0;

  drift_item_t   drift_items[$];
  drift_result_t predicted_positions[$];
  drift_item_t   cur_item;
  drift_result_t exp_res;
  int            mismatches   = 0;
  int            cycle_count  = 0;
  int            burst_left   = 1;
  int            gap_left     = 0;
  int            holdoff_req  = 0;
  int            holdoff_seen = 0;
  int            holdoff_left = 0;
  int            mode_left    = 0;
  rx_mode_t      stall_mode   = RX_FREE;

  drift_mobility_step_top #(
    .FRACTION_BITS(FRACTION_BITS),
    .NOISE_BITS   (NOISE_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_noise_x (in_noise_x),
    .in_sign_x  (in_sign_x),
    .in_noise_y (in_noise_y),
    .in_sign_y  (in_sign_y),
    .in_noise_z (in_noise_z),
    .in_sign_z  (in_sign_z),
    .in_load_x  (in_load_x),
    .in_load_y  (in_load_y),
    .in_load_z  (in_load_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_pos_z  (out_pos_z),
    .out_bounced(out_bounced),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One axis of a tick; returns 1 when the axis reflected off a wall.
  function automatic logic advance_axis(input int ax, input logic [NOISE_BITS-1:0] noise,
                                        input logic neg);
    longint a, mean, dev, tgt, acc, old_v, v, p, lim;
    logic   hit;
    a = (alpha_cfg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_cfg);
    mean = mean_cfg[ax];
    if (flip_track[ax])
      mean = -mean;
    dev = (longint'(spread_cfg[ax]) * longint'(noise)) >>> NOISE_BITS;
    if (neg)
      dev = -dev;
    tgt = mean + dev;
    old_v = vel_track[ax];
    acc = a * old_v + (longint'(ALPHA_ONE) - a) * tgt + (64'sd1 <<< (ROUND_SHIFT - 1));
    v = saturate(acc >>> ROUND_SHIFT, VEL_LO, VEL_HI);
    p = longint'(pos_track[ax]) + v;
    lim = longint'(limits_cfg[DIM_W*ax +: DIM_W]) <<< FRACTION_BITS;
    hit = 1'b0;
    // reflect once; the reflected value may still lie outside the field
    if (limits_cfg[BOUND_LSB + ax]) begin
      if (ax != Z_AXIS) begin
        if (p > lim) begin
          p = 2 * lim - p;
          hit = 1'b1;
        end else if (p < 0) begin
          p = -p;
          hit = 1'b1;
        end
      end else begin
        if (p < -lim) begin
          p = -2 * lim - p;
          hit = 1'b1;
        end else if (p > 0) begin
          p = -p;
          hit = 1'b1;
        end
      end
    end
    if (hit) begin
      v = saturate(-v, VEL_LO, VEL_HI);
      flip_track[ax] = ~flip_track[ax];
    end
    vel_track[ax] = v;
    pos_track[ax] = saturate(p, POS_LO, POS_HI);
    return hit;
  endfunction

  function automatic drift_result_t predict_drift(input drift_item_t it);
    drift_result_t r;
    r.bounced = '0;
    for (int ax = 0; ax < AXES; ax++) begin
      if (it.cmd == CMD_LOAD)
        pos_track[ax] = it.load[ax];
      else
        r.bounced[ax] = advance_axis(ax, it.noise[ax], it.sign[ax]);
      r.pos[ax] = pos_track[ax];
    end
    return r;
  endfunction

  function automatic void check_field(input string label, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endfunction

  task automatic queue_advance(input logic [NOISE_BITS-1:0] nx, input logic [NOISE_BITS-1:0] ny,
                               input logic [NOISE_BITS-1:0] nz, input logic [AXES-1:0] signs);
    drift_item_t it;
    it.cmd = CMD_ADVANCE;
    it.noise[0] = nx;
    it.noise[1] = ny;
    it.noise[2] = nz;
    it.sign = signs;
    for (int ax = 0; ax < AXES; ax++)
      it.load[ax] = $urandom();
    drift_items.push_back(it);
  endtask

  task automatic queue_load(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input logic [POS_W-1:0] z);
    drift_item_t it;
    it.cmd = CMD_LOAD;
    for (int ax = 0; ax < AXES; ax++)
      it.noise[ax] = $urandom();
    it.sign = $urandom();
    it.load[0] = x;
    it.load[1] = y;
    it.load[2] = z;
    drift_items.push_back(it);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [LIMITS_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ALPHA:    alpha_cfg     = value[ALPHA_W-1:0];
      REG_MEAN_X:   mean_cfg[0]   = value[MEAN_W-1:0];
      REG_MEAN_Y:   mean_cfg[1]   = value[MEAN_W-1:0];
      REG_MEAN_Z:   mean_cfg[2]   = value[MEAN_W-1:0];
      REG_SPREAD_X: spread_cfg[0] = value[SPREAD_W-1:0];
      REG_SPREAD_Y: spread_cfg[1] = value[SPREAD_W-1:0];
      REG_SPREAD_Z: spread_cfg[2] = value[SPREAD_W-1:0];
      default:      limits_cfg    = value;
    endcase
  endtask

  task automatic set_motion_regs(input logic [ALPHA_W-1:0] a,
                                 input logic [AXES-1:0][MEAN_W-1:0] m,
                                 input logic [AXES-1:0][SPREAD_W-1:0] s,
                                 input logic [LIMITS_W-1:0] lims);
    write_reg(REG_ALPHA, a);
    write_reg(REG_MEAN_X, m[0]);
    write_reg(REG_MEAN_Y, m[1]);
    write_reg(REG_MEAN_Z, m[2]);
    write_reg(REG_SPREAD_X, s[0]);
    write_reg(REG_SPREAD_Y, s[1]);
    write_reg(REG_SPREAD_Z, s[2]);
    write_reg(REG_LIMITS, lims);
  endtask

  // wait until every item is taken and every result is back, then let the block settle
  task automatic wait_drained();
    while (drift_items.size() != 0 || in_valid || predicted_positions.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // driver: offer items in bursts, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predicted_positions.push_back(predict_drift(cur_item));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (drift_items.size() > 0) begin
          cur_item = drift_items.pop_front();
          in_cmd     <= cur_item.cmd;
          in_noise_x <= cur_item.noise[0];
          in_sign_x  <= cur_item.sign[0];
          in_noise_y <= cur_item.noise[1];
          in_sign_y  <= cur_item.sign[1];
          in_noise_z <= cur_item.noise[2];
          in_sign_z  <= cur_item.sign[2];
          in_load_x  <= cur_item.load[0];
          in_load_y  <= cur_item.load[1];
          in_load_z  <= cur_item.load[2];
          in_valid   <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 :
                       $urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result item, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (predicted_positions.size() == 0) begin
        $display("%0t result with no item pending: pos %0d %0d %0d bounced %b",
                 $time, out_pos_x, out_pos_y, out_pos_z, out_bounced);
        mismatches++;
      end else begin
        exp_res = predicted_positions.pop_front();
        check_field("pos_x", exp_res.pos[0], out_pos_x);
        check_field("pos_y", exp_res.pos[1], out_pos_y);
        check_field("pos_z", exp_res.pos[2], out_pos_z);
        check_field("bounced", exp_res.bounced, out_bounced);
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      out_stall <= 1'b1;
    end else if (holdoff_seen != holdoff_req) begin
      // hold off long enough for the block to fill and stall its input
      holdoff_seen = holdoff_req;
      holdoff_left = HOLDOFF_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 512);
      end
      mode_left = mode_left - 1;
      case (stall_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    drift_item_t                     it;
    logic [ALPHA_W-1:0]              alpha_v;
    logic [AXES-1:0][MEAN_W-1:0]     mean_v;
    logic [AXES-1:0][SPREAD_W-1:0]   spread_v;
    logic [LIMITS_W-1:0]             limits_v;
    longint                          lim;
    int                              p, n, ax;

    for (ax = 0; ax < AXES; ax++) begin
      mean_cfg[ax]   = '0;
      spread_cfg[ax] = '0;
      pos_track[ax]  = '0;
      vel_track[ax]  = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero field on y and z, x unbounded
    queue_advance('0, '0, '0, 3'b000);
    queue_load(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    queue_advance('1, '1, '1, 3'b111);
    wait_drained();

    // largest steps against the largest field
    mean_v[0] = 23'h3F_FFFF;
    mean_v[1] = 23'h40_0000;
    mean_v[2] = 23'h3F_FFFF;
    for (ax = 0; ax < AXES; ax++)
      spread_v[ax] = '1;
    set_motion_regs('0, mean_v, spread_v, 51'h7_FFFF_FFFF_FFFF);
    queue_load('0, '0, '0);
    queue_advance('1, '1, '1, 3'b000);
    queue_advance('1, '1, '1, 3'b111);
    queue_advance('0, '0, '0, 3'b000);
    queue_load(32'h00FF_FF00, 32'h00FF_FF00, 32'hFF00_0100);
    queue_advance(16'h8000, 16'h8000, 16'h8000, 3'b010);
    queue_load(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_advance('1, '1, '1, 3'b000);
    wait_drained();

    // alpha above one keeps the old velocity; x unbounded runs into saturation
    write_reg(REG_ALPHA, 17'h1_FFFF);
    write_reg(REG_LIMITS, 51'h6_FFFF_FFFF_FFFF);
    queue_advance(16'h1234, 16'hABCD, 16'h5555, 3'b101);
    queue_load(32'h7FFF_FF00, '0, '0);
    queue_advance(16'hFFFF, 16'h0001, 16'h7FFF, 3'b000);
    queue_advance(16'h0F0F, 16'hF0F0, 16'h00FF, 3'b011);
    wait_drained();
    write_reg(REG_ALPHA, ALPHA_ONE);
    queue_advance(16'h4321, 16'h8765, 16'hCBA9, 3'b110);
    wait_drained();
    write_reg(REG_ALPHA, 17'h0_8000);
    queue_advance(16'h0001, 16'hFFFE, 16'h8001, 3'b001);
    queue_advance(16'h7FFE, 16'h0003, 16'hC000, 3'b100);
    wait_drained();

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == 0)
        alpha_v = '0;
      else if (p == 1)
        alpha_v = ALPHA_ONE;
      else if (p == 2)
        alpha_v = '1;
      else
        alpha_v = $urandom_range(0, 1) ? $urandom_range(0, ALPHA_ONE) :
                                         $urandom_range(60000, 131071);
      for (ax = 0; ax < AXES; ax++) begin
        if (p == 0) begin
          mean_v[ax]   = 23'h3F_FFFF;
          spread_v[ax] = '1;
          limits_v[DIM_W*ax +: DIM_W] = '1;
        end else if (p == 1) begin
          mean_v[ax]   = 23'h40_0000;
          spread_v[ax] = '0;
          limits_v[DIM_W*ax +: DIM_W] = '0;
        end else begin
          mean_v[ax]   = $urandom_range(0, 1) ? $urandom() : int'($urandom_range(0, 2000)) - 1000;
          spread_v[ax] = $urandom() >> $urandom_range(10, 31);
          limits_v[DIM_W*ax +: DIM_W] = ($urandom_range(0, 3) == 0) ? $urandom() :
                                                                       $urandom_range(0, 300);
        end
      end
      limits_v[LIMITS_W-1:BOUND_LSB] = (p == 0) ? 3'b111 : ((p == 1) ? 3'b000 : $urandom());
      set_motion_regs(alpha_v, mean_v, spread_v, limits_v);

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.cmd = ($urandom_range(0, 9) == 0) ? CMD_LOAD : CMD_ADVANCE;
        for (ax = 0; ax < AXES; ax++) begin
          it.noise[ax] = $urandom();
          it.sign[ax]  = $urandom();
          lim = longint'(limits_cfg[DIM_W*ax +: DIM_W]) <<< FRACTION_BITS;
          case ($urandom_range(0, 3))
            0: it.load[ax] = $urandom();
            1: it.load[ax] = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 1 << 24) :
                                                    32'h8000_0000 + $urandom_range(0, 1 << 24);
            default: begin
              // somewhere inside the field, near a wall now and then
              it.load[ax] = $urandom_range(0, lim);
              if (ax == Z_AXIS)
                it.load[ax] = -it.load[ax];
            end
          endcase
        end
        drift_items.push_back(it);
      end
      if (p == 2 || p == 5)
        holdoff_req++;
      wait_drained();
    end

    if (mismatches == 0 && predicted_positions.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
